// File: hw/rtl/kdv_pkg.sv
// Shared types and constants for the kick drum voice.
package kdv_pkg;

   // Configuration port geometry and register widths
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 31;
   localparam int BODY_INC_W   = 31;
   localparam int DEPTH_W      = 16;
   localparam int DECAY_W      = 24;
   localparam int NOISE_AMT_W  = 17;
   localparam int LEN_CFG_W    = 18;

   // Register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_BODY_PHASE_INC = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_PITCH_DEPTH    = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_PITCH_DECAY    = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_CLICK_DECAY    = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_AMP_DECAY      = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_NOISE_AMOUNT   = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] CSR_LENGTH_SAMPLES = 3'd6;

   // Register reset values
   localparam logic [BODY_INC_W-1:0]  RST_BODY_PHASE_INC = 31'd4473924;
   localparam logic [DEPTH_W-1:0]     RST_PITCH_DEPTH    = 16'd4096;
   localparam logic [DECAY_W-1:0]     RST_PITCH_DECAY    = 24'd16770227;
   localparam logic [DECAY_W-1:0]     RST_CLICK_DECAY    = 24'd16759748;
   localparam logic [DECAY_W-1:0]     RST_AMP_DECAY      = 24'd16775468;
   localparam logic [NOISE_AMT_W-1:0] RST_NOISE_AMOUNT   = 17'd0;
   localparam logic [LEN_CFG_W-1:0]   RST_LENGTH_SAMPLES = 18'd48000;

   // Arithmetic constants
   localparam logic [DECAY_W-1:0]     ENV_ONE       = 24'hFFFFFF;
   localparam logic [NOISE_AMT_W-1:0] NOISE_AMT_MAX = 17'd65536;
   localparam logic [16:0]            PITCH_UNITY   = 17'd4096;
   localparam logic [30:0]            SIN_A1        = 31'd1686629713;
   localparam logic [30:0]            SIN_A3        = 31'd693598669;
   localparam logic [30:0]            SIN_A5        = 31'd85569306;
   localparam logic [30:0]            SIN_A7        = 31'd5026996;
   localparam logic [30:0]            SIN_A9        = 31'd172272;
   localparam logic [30:0]            X_ONE         = 31'd1073741824;
   localparam logic [31:0]            SIN_ROUND     = 32'd16384;
   // floor(2^30 / 127), quotient estimate is low by at most one
   localparam logic [23:0]            RECIP_127     = 24'd8454660;
   localparam logic [23:0]            DIV_127       = 24'd127;

   // Channel payloads
   typedef struct packed {
      logic              retrigger;
      logic [6:0]        strike_velocity;
      logic signed [15:0] noise_sample;
   } req_type;

   typedef struct packed {
      logic signed [15:0] audio_out;
      logic              voice_active;
   } rsp_type;

   // Sequencer steps, one shared multiply each
   typedef enum logic [3:0] {
      STP_PITCH_MOD   = 4'd0,
      STP_PHASE_INC   = 4'd1,
      STP_NOISE_ENV   = 4'd2,
      STP_NOISE_AMT   = 4'd3,
      STP_SQUARE      = 4'd4,
      STP_HORNER7     = 4'd5,
      STP_HORNER5     = 4'd6,
      STP_HORNER3     = 4'd7,
      STP_HORNER1     = 4'd8,
      STP_SINE_Y      = 4'd9,
      STP_AMP_VEL     = 4'd10,
      STP_SCALE       = 4'd11,
      STP_RECIP       = 4'd12,
      STP_PITCH_DECAY = 4'd13,
      STP_CLICK_DECAY = 4'd14,
      STP_AMP_DECAY   = 4'd15
   } step_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_MUL  = 2'd1,
      ST_WB   = 2'd2,
      ST_EMIT = 2'd3
   } state_type;

   // Sequencer to datapath controls
   typedef struct packed {
      logic     idle;
      logic     mul_en;
      logic     wb_en;
      logic     emit;
      step_type step;
   } ctl_type;

endpackage

// File: hw/rtl/kdv_ctrl.sv
// Sequencer that walks the shared multiplier through the per-sample steps.
module kdv_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start_calc,
   input  logic             start_emit,
   input  logic             out_free,
   output kdv_pkg::ctl_type ctl
);

   kdv_pkg::state_type state_ff, state_in;
   kdv_pkg::step_type  step_ff, step_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         kdv_pkg::ST_IDLE: begin
            if (start_calc) state_in = kdv_pkg::ST_MUL;
            else if (start_emit) state_in = kdv_pkg::ST_EMIT;
         end
         kdv_pkg::ST_MUL: begin
            state_in = kdv_pkg::ST_WB;
         end
         kdv_pkg::ST_WB: begin
            if (step_ff == kdv_pkg::STP_AMP_DECAY) state_in = kdv_pkg::ST_EMIT;
            else state_in = kdv_pkg::ST_MUL;
         end
         kdv_pkg::ST_EMIT: begin
            if (out_free) state_in = kdv_pkg::ST_IDLE;
         end
         default: begin
            state_in = kdv_pkg::ST_IDLE;
         end
      endcase
   end

   // Step counter advances after each writeback
   always_comb begin
      step_in = step_ff;
      if (state_ff == kdv_pkg::ST_IDLE) begin
         step_in = kdv_pkg::STP_PITCH_MOD;
      end else if (state_ff == kdv_pkg::ST_WB && step_ff != kdv_pkg::STP_AMP_DECAY) begin
         step_in = kdv_pkg::step_type'(4'(step_ff) + 4'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= kdv_pkg::ST_IDLE;
         step_ff  <= kdv_pkg::STP_PITCH_MOD;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   // Outputs
   always_comb begin
      ctl.idle   = (state_ff == kdv_pkg::ST_IDLE);
      ctl.mul_en = (state_ff == kdv_pkg::ST_MUL);
      ctl.wb_en  = (state_ff == kdv_pkg::ST_WB);
      ctl.emit   = (state_ff == kdv_pkg::ST_EMIT);
      ctl.step   = step_ff;
   end

`ifndef NO_ASSERTIONS
   // A writeback always follows its multiply
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == kdv_pkg::ST_WB) |-> $past(state_ff == kdv_pkg::ST_MUL))
      else $error("writeback without multiply");
   // The sequence only leaves for output after the last step
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == kdv_pkg::ST_WB && step_ff != kdv_pkg::STP_AMP_DECAY)
      |=> (state_ff == kdv_pkg::ST_MUL))
      else $error("step sequence cut short");
   // Step counter is rewound to the first step whenever the sequencer is idle
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == kdv_pkg::ST_IDLE) |=> (step_ff == kdv_pkg::STP_PITCH_MOD))
      else $error("step counter not rewound");
`endif

endmodule

// File: hw/rtl/kick_drum_voice_unit.sv
// Kick drum voice: one audio sample per request, built around one shared multiplier.
// Timing: a playing tick runs 16 multiplies, each a multiply state and a writeback state,
// then the output state; a silent tick goes straight to the output state, which waits on rsp_stall.
// Requests stall until the sequencer is idle again, so a new tick is taken only after the last is
// emitted; the multiplier is the single arithmetic unit and every step waits on it.
// Reset: synchronous, active high; configuration registers return to their defaults, the voice goes silent.
module kick_drum_voice_unit #(
   parameter int SINE_TABLE_BITS = 10,
   parameter int LENGTH_BITS     = 18
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  kdv_pkg::req_type                  req_payload,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output kdv_pkg::rsp_type                  rsp_payload,
   input  logic                              csr_we,
   input  logic [kdv_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [kdv_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int QB    = SINE_TABLE_BITS - 2;
   localparam int CMP_W = (LENGTH_BITS > kdv_pkg::LEN_CFG_W) ? LENGTH_BITS : kdv_pkg::LEN_CFG_W;
   localparam logic [CMP_W-1:0] LEN_MAX = CMP_W'((64'd1 << LENGTH_BITS) - 64'd1);

   // Configuration registers
   logic [kdv_pkg::BODY_INC_W-1:0]  body_inc_ff;
   logic [kdv_pkg::DEPTH_W-1:0]     depth_ff;
   logic [kdv_pkg::DECAY_W-1:0]     pdec_ff, cdec_ff, adec_ff;
   logic [kdv_pkg::NOISE_AMT_W-1:0] namt_ff;
   logic [kdv_pkg::LEN_CFG_W-1:0]   len_ff;

   // Voice state
   logic                        playing_ff;
   logic [LENGTH_BITS-1:0]      position_ff;
   logic [31:0]                 phase_ff;
   logic [6:0]                  vel_ff;
   logic [kdv_pkg::DECAY_W-1:0] penv_ff, cenv_ff, aenv_ff;

   // Working registers
   logic [63:0] prod_ff;
   logic [15:0] nmag_ff;
   logic        nneg_ff;
   logic [16:0] m_ff;
   logic [15:0] cm_ff;
   logic [15:0] click_ff;
   logic [30:0] x_ff, s_ff, r_ff;
   logic        sin_neg_ff;
   logic signed [15:0] sine_ff;
   logic [30:0] av_ff;
   logic        sum_neg_ff;
   logic [16:0] sum_mag_ff;
   logic [22:0] t_ff;
   logic [16:0] q_ff;
   logic signed [15:0] res_audio_ff;
   logic        res_active_ff;
   logic        rsp_valid_ff;
   kdv_pkg::rsp_type rsp_ff;

   kdv_pkg::ctl_type ctl;

   // Accept decode
   logic                        req_fire, play_now, ended, start_calc, start_emit, out_free;
   logic [LENGTH_BITS-1:0]      pos_now;
   logic [CMP_W-1:0]            len_ext, eff_len;
   logic [kdv_pkg::NOISE_AMT_W-1:0] amt;
   logic [15:0]                 noise_mag;

   // Writeback helpers
   logic [SINE_TABLE_BITS-1:0]  idx;
   logic [QB-1:0]               quarter_pos;
   logic [30:0]                 x_raw;
   logic [30:0]                 horner_k;
   logic [31:0]                 y_round;
   logic [16:0]                 y_q;
   logic [14:0]                 sine_mag;
   logic signed [16:0]          click_s, sum_s;
   logic [23:0]                 div_rem;
   logic [15:0]                 audio_pos, audio_neg;
   logic [31:0]                 opa, opb;

   assign req_stall = !ctl.idle;
   assign req_fire  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Start of tick: retrigger and end-of-voice decision
   always_comb begin
      len_ext    = CMP_W'(len_ff);
      eff_len    = (len_ext > LEN_MAX) ? LEN_MAX : len_ext;
      play_now   = req_payload.retrigger || playing_ff;
      pos_now    = req_payload.retrigger ? '0 : position_ff;
      ended      = (CMP_W'(pos_now) >= eff_len);
      start_calc = req_fire && play_now && !ended;
      start_emit = req_fire && !(play_now && !ended);
      amt        = (namt_ff > kdv_pkg::NOISE_AMT_MAX) ? kdv_pkg::NOISE_AMT_MAX : namt_ff;
      noise_mag  = req_payload.noise_sample[15] ? 16'(~req_payload.noise_sample + 16'sd1)
                                                : 16'(req_payload.noise_sample);
   end

   kdv_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start_calc (start_calc),
      .start_emit (start_emit),
      .out_free   (out_free),
      .ctl        (ctl)
   );

   // Shared multiplier operand select
   always_comb begin
      opa = '0;
      opb = '0;
      case (ctl.step)
         kdv_pkg::STP_PITCH_MOD: begin
            opa = 32'(depth_ff);   opb = 32'(penv_ff);
         end
         kdv_pkg::STP_PHASE_INC: begin
            opa = 32'(body_inc_ff); opb = 32'(m_ff);
         end
         kdv_pkg::STP_NOISE_ENV: begin
            opa = 32'(nmag_ff);    opb = 32'(cenv_ff);
         end
         kdv_pkg::STP_NOISE_AMT: begin
            opa = 32'(cm_ff);      opb = 32'(amt);
         end
         kdv_pkg::STP_SQUARE: begin
            opa = 32'(x_ff);       opb = 32'(x_ff);
         end
         kdv_pkg::STP_HORNER7, kdv_pkg::STP_HORNER5,
         kdv_pkg::STP_HORNER3, kdv_pkg::STP_HORNER1: begin
            opa = 32'(r_ff);       opb = 32'(s_ff);
         end
         kdv_pkg::STP_SINE_Y: begin
            opa = 32'(r_ff);       opb = 32'(x_ff);
         end
         kdv_pkg::STP_AMP_VEL: begin
            opa = 32'(aenv_ff);    opb = 32'(vel_ff);
         end
         kdv_pkg::STP_SCALE: begin
            opa = 32'(sum_mag_ff); opb = 32'(av_ff);
         end
         kdv_pkg::STP_RECIP: begin
            opa = 32'(t_ff);       opb = 32'(kdv_pkg::RECIP_127);
         end
         kdv_pkg::STP_PITCH_DECAY: begin
            opa = 32'(penv_ff);    opb = 32'(pdec_ff);
         end
         kdv_pkg::STP_CLICK_DECAY: begin
            opa = 32'(cenv_ff);    opb = 32'(cdec_ff);
         end
         kdv_pkg::STP_AMP_DECAY: begin
            opa = 32'(aenv_ff);    opb = 32'(adec_ff);
         end
         default: begin
            opa = '0;              opb = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctl.mul_en) prod_ff <= opa * opb;
   end

   // Writeback helpers: quarter-wave position, Horner constant, rounding, divide fix-up
   always_comb begin
      idx         = phase_ff[31 -: SINE_TABLE_BITS];
      quarter_pos = idx[QB-1:0];
      x_raw       = 31'(quarter_pos) << (30 - QB);
      case (ctl.step)
         kdv_pkg::STP_HORNER7: horner_k = kdv_pkg::SIN_A7;
         kdv_pkg::STP_HORNER5: horner_k = kdv_pkg::SIN_A5;
         kdv_pkg::STP_HORNER3: horner_k = kdv_pkg::SIN_A3;
         default:              horner_k = kdv_pkg::SIN_A1;
      endcase
      y_round  = 32'(prod_ff[60:30]) + kdv_pkg::SIN_ROUND;
      y_q      = y_round[31:15];
      sine_mag = (y_q > 17'd32767) ? 15'd32767 : y_q[14:0];
      click_s  = nneg_ff ? -$signed({1'b0, click_ff}) : $signed({1'b0, click_ff});
      sum_s    = 17'(sine_ff) + click_s;
      div_rem  = 24'(t_ff) - ((24'(q_ff) << 7) - 24'(q_ff));
      audio_pos = (q_ff > 17'd32767) ? 16'h7FFF : q_ff[15:0];
      audio_neg = (q_ff > 17'd32768) ? 16'h8000 : 16'(~q_ff[15:0] + 16'd1);
   end

   // Voice state and step writeback
   always_ff @(posedge clock) begin
      if (reset) begin
         playing_ff  <= 1'b0;
         position_ff <= '0;
         phase_ff    <= '0;
         vel_ff      <= '0;
         penv_ff     <= kdv_pkg::ENV_ONE;
         cenv_ff     <= kdv_pkg::ENV_ONE;
         aenv_ff     <= kdv_pkg::ENV_ONE;
      end else if (req_fire) begin
         if (req_payload.retrigger) begin
            position_ff <= '0;
            phase_ff    <= '0;
            vel_ff      <= req_payload.strike_velocity;
            penv_ff     <= kdv_pkg::ENV_ONE;
            cenv_ff     <= kdv_pkg::ENV_ONE;
            aenv_ff     <= kdv_pkg::ENV_ONE;
         end
         playing_ff <= play_now && !ended;
      end else if (ctl.wb_en) begin
         case (ctl.step)
            kdv_pkg::STP_PHASE_INC:   phase_ff    <= phase_ff + prod_ff[43:12];
            kdv_pkg::STP_PITCH_DECAY: penv_ff     <= prod_ff[47:24];
            kdv_pkg::STP_CLICK_DECAY: cenv_ff     <= prod_ff[47:24];
            kdv_pkg::STP_AMP_DECAY: begin
               aenv_ff     <= prod_ff[47:24];
               position_ff <= position_ff + 1'b1;
            end
            default: begin
               phase_ff <= phase_ff;
            end
         endcase
      end
   end

   // Datapath temporaries
   always_ff @(posedge clock) begin
      if (req_fire) begin
         nmag_ff       <= noise_mag;
         nneg_ff       <= req_payload.noise_sample[15];
         res_audio_ff  <= '0;
         res_active_ff <= 1'b0;
      end else if (ctl.wb_en) begin
         case (ctl.step)
            kdv_pkg::STP_PITCH_MOD: m_ff <= kdv_pkg::PITCH_UNITY + 17'(prod_ff[39:24]);
            kdv_pkg::STP_NOISE_ENV: begin
               cm_ff      <= prod_ff[39:24];
               x_ff       <= idx[QB] ? (kdv_pkg::X_ONE - x_raw) : x_raw;
               sin_neg_ff <= idx[QB+1];
            end
            kdv_pkg::STP_NOISE_AMT: click_ff <= prod_ff[31:16];
            kdv_pkg::STP_SQUARE: begin
               s_ff <= prod_ff[60:30];
               r_ff <= kdv_pkg::SIN_A9;
            end
            kdv_pkg::STP_HORNER7, kdv_pkg::STP_HORNER5,
            kdv_pkg::STP_HORNER3, kdv_pkg::STP_HORNER1: begin
               r_ff <= horner_k - prod_ff[60:30];
            end
            kdv_pkg::STP_SINE_Y: begin
               sine_ff <= sin_neg_ff ? -$signed({1'b0, sine_mag}) : $signed({1'b0, sine_mag});
            end
            kdv_pkg::STP_AMP_VEL: begin
               av_ff      <= prod_ff[30:0];
               sum_neg_ff <= sum_s[16];
               sum_mag_ff <= sum_s[16] ? 17'(-sum_s) : 17'(sum_s);
            end
            kdv_pkg::STP_SCALE: t_ff <= prod_ff[47:25];
            kdv_pkg::STP_RECIP: q_ff <= prod_ff[46:30];
            kdv_pkg::STP_PITCH_DECAY: begin
               if (div_rem >= kdv_pkg::DIV_127) q_ff <= q_ff + 17'd1;
            end
            kdv_pkg::STP_CLICK_DECAY: begin
               res_audio_ff <= sum_neg_ff ? $signed(audio_neg) : $signed(audio_pos);
            end
            kdv_pkg::STP_AMP_DECAY: res_active_ff <= 1'b1;
            default: begin
               m_ff <= m_ff;
            end
         endcase
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.emit && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.emit && out_free) begin
         rsp_ff.audio_out    <= res_audio_ff;
         rsp_ff.voice_active <= res_active_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         body_inc_ff <= kdv_pkg::RST_BODY_PHASE_INC;
         depth_ff    <= kdv_pkg::RST_PITCH_DEPTH;
         pdec_ff     <= kdv_pkg::RST_PITCH_DECAY;
         cdec_ff     <= kdv_pkg::RST_CLICK_DECAY;
         adec_ff     <= kdv_pkg::RST_AMP_DECAY;
         namt_ff     <= kdv_pkg::RST_NOISE_AMOUNT;
         len_ff      <= kdv_pkg::RST_LENGTH_SAMPLES;
      end else if (csr_we) begin
         case (csr_addr)
            kdv_pkg::CSR_BODY_PHASE_INC: body_inc_ff <= csr_wdata[kdv_pkg::BODY_INC_W-1:0];
            kdv_pkg::CSR_PITCH_DEPTH:    depth_ff    <= csr_wdata[kdv_pkg::DEPTH_W-1:0];
            kdv_pkg::CSR_PITCH_DECAY:    pdec_ff     <= csr_wdata[kdv_pkg::DECAY_W-1:0];
            kdv_pkg::CSR_CLICK_DECAY:    cdec_ff     <= csr_wdata[kdv_pkg::DECAY_W-1:0];
            kdv_pkg::CSR_AMP_DECAY:      adec_ff     <= csr_wdata[kdv_pkg::DECAY_W-1:0];
            kdv_pkg::CSR_NOISE_AMOUNT:   namt_ff     <= csr_wdata[kdv_pkg::NOISE_AMT_W-1:0];
            kdv_pkg::CSR_LENGTH_SAMPLES: len_ff      <= csr_wdata[kdv_pkg::LEN_CFG_W-1:0];
            default: begin
               len_ff <= len_ff;
            end
         endcase
      end
   end

`ifndef NO_ASSERTIONS
   // An accepted request always leaves the idle state
   assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !ctl.idle)
      else $error("request accepted but sequencer stayed idle");
   // A silent tick carries a zero sample
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.voice_active || rsp_ff.audio_out == 16'sd0))
      else $error("inactive tick with nonzero sample");
   // A new response only appears out of the output step
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(ctl.emit))
      else $error("response without output step");
   // Position advances by one on each finished sample
   assert property (@(posedge clock) disable iff (reset)
      (ctl.wb_en && ctl.step == kdv_pkg::STP_AMP_DECAY)
      |=> (position_ff == $past(position_ff) + 1'b1))
      else $error("position did not advance after a sample");
`endif

endmodule

// File: test/kdv_result_checker.sv
// Checker for the kick drum voice: models each accepted tick and compares the returned samples.
`timescale 1ns / 1ps
module kdv_result_checker #(
   parameter int SINE_TABLE_BITS = 10,
   parameter int LENGTH_BITS     = 18
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  kdv_pkg::req_type               req_payload,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  kdv_pkg::rsp_type               rsp_payload,
   input  logic                           csr_we,
   input  logic [kdv_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [kdv_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int unsigned                    mismatches,
   output int unsigned                    samples_owed
);

   localparam int              QUARTER_BITS = SINE_TABLE_BITS - 2;
   localparam longint unsigned LEN_LIMIT    = (64'd1 << LENGTH_BITS) - 1;
   localparam longint unsigned LEVEL_ONE    = 64'hFFFFFF;
   localparam longint unsigned NOISE_UNITY  = 64'd65536;
   localparam longint unsigned DEPTH_UNITY  = 64'd4096;

   // Q30 coefficients of the odd sine polynomial
   localparam longint unsigned SINE_C1 = 64'd1686629713;
   localparam longint unsigned SINE_C3 = 64'd693598669;
   localparam longint unsigned SINE_C5 = 64'd85569306;
   localparam longint unsigned SINE_C7 = 64'd5026996;
   localparam longint unsigned SINE_C9 = 64'd172272;

   // Register copy
   logic [kdv_pkg::BODY_INC_W-1:0]  cfg_body_inc;
   logic [kdv_pkg::DEPTH_W-1:0]     cfg_depth;
   logic [kdv_pkg::DECAY_W-1:0]     cfg_pitch_decay;
   logic [kdv_pkg::DECAY_W-1:0]     cfg_click_decay;
   logic [kdv_pkg::DECAY_W-1:0]     cfg_amp_decay;
   logic [kdv_pkg::NOISE_AMT_W-1:0] cfg_noise_amt;
   logic [kdv_pkg::LEN_CFG_W-1:0]   cfg_length;

   // Voice state copy
   logic                   voice_on;
   logic [LENGTH_BITS-1:0] tick_pos;
   logic [31:0]            osc_acc;
   logic [6:0]             strike_vel;
   logic [23:0]            pitch_lvl;
   logic [23:0]            click_lvl;
   logic [23:0]            amp_lvl;

   kdv_pkg::rsp_type expected_samples[$];
   int unsigned      fail_total = 0;

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch at %0t ns: %s got %0d expected %0d", $time, what, got, want);
      fail_total++;
   endtask

   // Table entry: Horner evaluation of the polynomial over the mirrored quarter wave
   function automatic logic signed [15:0] sine_value(input logic [SINE_TABLE_BITS-1:0] idx);
      logic [1:0]      quad;
      longint unsigned x;
      longint unsigned sq;
      longint unsigned acc;
      longint unsigned mag;
      quad = idx[SINE_TABLE_BITS-1 -: 2];
      x = 64'(idx[QUARTER_BITS-1:0]) << (30 - QUARTER_BITS);
      if (quad[0])
         x = (64'd1 << 30) - x;
      sq  = (x * x) >> 30;
      acc = SINE_C9;
      acc = SINE_C7 - ((acc * sq) >> 30);
      acc = SINE_C5 - ((acc * sq) >> 30);
      acc = SINE_C3 - ((acc * sq) >> 30);
      acc = SINE_C1 - ((acc * sq) >> 30);
      mag = (acc * x) >> 30;
      mag = (mag + 64'd16384) >> 15;
      if (mag > 64'd32767)
         mag = 64'd32767;
      return quad[1] ? -$signed(mag[15:0]) : $signed(mag[15:0]);
   endfunction

   // v * m >> sh, magnitude truncated toward zero
   function automatic longint scale_mag(input longint v, input longint unsigned m, input int sh);
      longint unsigned mag;
      longint unsigned prod;
      mag  = (v < 0) ? -v : v;
      prod = (mag * m) >> sh;
      return (v < 0) ? -longint'(prod) : longint'(prod);
   endfunction

   // One sample tick of the voice
   task automatic synth_tick(input kdv_pkg::req_type req, output kdv_pkg::rsp_type res);
      longint unsigned eff_len;
      longint unsigned amount;
      longint unsigned bend;
      longint unsigned step_inc;
      longint          click;
      longint          mix;
      longint          prod;
      longint          mag;
      longint          level;
      res     = '0;
      eff_len = (64'(cfg_length) > LEN_LIMIT) ? LEN_LIMIT : 64'(cfg_length);
      amount  = (64'(cfg_noise_amt) > NOISE_UNITY) ? NOISE_UNITY : 64'(cfg_noise_amt);
      if (req.retrigger) begin
         voice_on   = 1'b1;
         tick_pos   = '0;
         osc_acc    = '0;
         strike_vel = req.strike_velocity;
         pitch_lvl  = 24'(LEVEL_ONE);
         click_lvl  = 24'(LEVEL_ONE);
         amp_lvl    = 24'(LEVEL_ONE);
      end
      if (voice_on) begin
         if (64'(tick_pos) >= eff_len) begin
            // end of voice: this tick is already silent
            voice_on = 1'b0;
         end else begin
            bend     = DEPTH_UNITY + ((64'(cfg_depth) * 64'(pitch_lvl)) >> 24);
            step_inc = (64'(cfg_body_inc) * bend) >> 12;
            osc_acc  = osc_acc + step_inc[31:0];

            click = scale_mag(longint'($signed(req.noise_sample)), 64'(click_lvl), 24);
            click = scale_mag(click, amount, 16);
            mix   = longint'(sine_value(osc_acc[31 -: SINE_TABLE_BITS])) + click;

            prod  = scale_mag(mix, 64'(amp_lvl) * 64'(strike_vel), 0);
            mag   = (prod < 0) ? -prod : prod;
            mag   = mag / (longint'(127) << 25);
            level = (prod < 0) ? -mag : mag;
            if (level > 32767)
               level = 32767;
            if (level < -32768)
               level = -32768;

            pitch_lvl = 24'((64'(pitch_lvl) * 64'(cfg_pitch_decay)) >> 24);
            click_lvl = 24'((64'(click_lvl) * 64'(cfg_click_decay)) >> 24);
            amp_lvl   = 24'((64'(amp_lvl) * 64'(cfg_amp_decay)) >> 24);
            tick_pos  = tick_pos + 1'b1;

            res.audio_out    = level[15:0];
            res.voice_active = 1'b1;
         end
      end
   endtask

   // Channel monitor: register writes, request acceptance, response comparison
   always @(posedge clock) begin
      kdv_pkg::rsp_type want;
      kdv_pkg::rsp_type got;
      if (reset) begin
         cfg_body_inc    = kdv_pkg::RST_BODY_PHASE_INC;
         cfg_depth       = kdv_pkg::RST_PITCH_DEPTH;
         cfg_pitch_decay = kdv_pkg::RST_PITCH_DECAY;
         cfg_click_decay = kdv_pkg::RST_CLICK_DECAY;
         cfg_amp_decay   = kdv_pkg::RST_AMP_DECAY;
         cfg_noise_amt   = kdv_pkg::RST_NOISE_AMOUNT;
         cfg_length      = kdv_pkg::RST_LENGTH_SAMPLES;
         voice_on        = 1'b0;
         tick_pos        = '0;
         osc_acc         = '0;
         strike_vel      = '0;
         pitch_lvl       = 24'(LEVEL_ONE);
         click_lvl       = 24'(LEVEL_ONE);
         amp_lvl         = 24'(LEVEL_ONE);
         expected_samples.delete();
      end else begin
         if (csr_we) begin
            case (csr_addr)
               kdv_pkg::CSR_BODY_PHASE_INC:
                  cfg_body_inc    = csr_wdata[kdv_pkg::BODY_INC_W-1:0];
               kdv_pkg::CSR_PITCH_DEPTH:
                  cfg_depth       = csr_wdata[kdv_pkg::DEPTH_W-1:0];
               kdv_pkg::CSR_PITCH_DECAY:
                  cfg_pitch_decay = csr_wdata[kdv_pkg::DECAY_W-1:0];
               kdv_pkg::CSR_CLICK_DECAY:
                  cfg_click_decay = csr_wdata[kdv_pkg::DECAY_W-1:0];
               kdv_pkg::CSR_AMP_DECAY:
                  cfg_amp_decay   = csr_wdata[kdv_pkg::DECAY_W-1:0];
               kdv_pkg::CSR_NOISE_AMOUNT:
                  cfg_noise_amt   = csr_wdata[kdv_pkg::NOISE_AMT_W-1:0];
               kdv_pkg::CSR_LENGTH_SAMPLES:
                  cfg_length      = csr_wdata[kdv_pkg::LEN_CFG_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            synth_tick(req_payload, want);
            expected_samples.push_back(want);
         end
         if (rsp_valid && !rsp_stall) begin
            got = rsp_payload;
            if (expected_samples.size() == 0) begin
               report_mismatch("response with no request waiting, audio_out",
                               longint'(got.audio_out), 0);
            end else begin
               want = expected_samples.pop_front();
               if (got.audio_out !== want.audio_out)
                  report_mismatch("audio_out", longint'(got.audio_out),
                                  longint'(want.audio_out));
               if (got.voice_active !== want.voice_active)
                  report_mismatch("voice_active", longint'(got.voice_active),
                                  longint'(want.voice_active));
            end
         end
      end
      samples_owed <= expected_samples.size();
      mismatches   <= fail_total;
   end

endmodule

// File: test/kick_drum_voice_unit_tb.sv
// Top of the kick drum voice testbench: clock, reset, stimulus, back-pressure and verdict.
`timescale 1ns / 1ps
module kick_drum_voice_unit_tb;

   localparam int                    RESET_CYCLES = 12;
   localparam int unsigned           CYCLE_LIMIT  = 600000;
   localparam int                    TARGET_TICKS = 1350;
   localparam int                    DRAIN_TAIL   = 60;
   localparam logic [kdv_pkg::CSR_ADDR_W-1:0]  CSR_UNUSED = 3'd7;
   localparam logic [kdv_pkg::LEN_CFG_W-1:0]   LEN_TOP    = '1;
   localparam logic [kdv_pkg::NOISE_AMT_W-1:0] AMT_TOP    = '1;

   logic                           clock       = 1'b0;
   logic                           reset       = 1'b1;
   logic                           req_valid   = 1'b0;
   logic                           req_stall;
   kdv_pkg::req_type               req_payload = '0;
   logic                           rsp_valid;
   logic                           rsp_stall   = 1'b0;
   kdv_pkg::rsp_type               rsp_payload;
   logic                           csr_we      = 1'b0;
   logic [kdv_pkg::CSR_ADDR_W-1:0] csr_addr    = '0;
   logic [kdv_pkg::CSR_DATA_W-1:0] csr_wdata   = '0;

   int unsigned mismatches;
   int unsigned samples_owed;
   int unsigned cycle_count = 0;

   // Sender burst control
   int burst_left = 0;
   int gap_max    = 4;
   int ticks_sent = 0;

   // Receiver stall pattern
   logic [1:0] stall_mode = 2'd0;
   int         mode_left  = 0;
   logic [4:0] stall_tick = '0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   kick_drum_voice_unit u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_addr    (csr_addr),
      .csr_wdata   (csr_wdata)
   );

   kdv_result_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_payload  (req_payload),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_payload  (rsp_payload),
      .csr_we       (csr_we),
      .csr_addr     (csr_addr),
      .csr_wdata    (csr_wdata),
      .mismatches   (mismatches),
      .samples_owed (samples_owed)
   );

   // Run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Response back-pressure: the stall mode is redrawn at random intervals
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_mode <= 2'd0;
         mode_left  <= 0;
         stall_tick <= '0;
      end else begin
         stall_tick <= stall_tick + 1'b1;
         if (mode_left == 0) begin
            stall_mode <= 2'($urandom_range(0, 3));
            mode_left  <= $urandom_range(50, 400);
         end else begin
            mode_left <= mode_left - 1;
         end
         case (stall_mode)
            2'd0: rsp_stall <= 1'b0;
            2'd1: rsp_stall <= ($urandom_range(0, 3) == 0);
            2'd2: rsp_stall <= 1'($urandom_range(0, 1));
            default: rsp_stall <= (stall_tick < 5'd24);
         endcase
      end
   end

   task automatic csr_write(input logic [kdv_pkg::CSR_ADDR_W-1:0] addr,
                            input logic [kdv_pkg::CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= data;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // Full register set, plus a write to the unused index that must be ignored
   task automatic apply_config(input logic [kdv_pkg::BODY_INC_W-1:0] body,
                               input logic [kdv_pkg::DEPTH_W-1:0] depth,
                               input logic [kdv_pkg::DECAY_W-1:0] pitch_dec,
                               input logic [kdv_pkg::DECAY_W-1:0] click_dec,
                               input logic [kdv_pkg::DECAY_W-1:0] amp_dec,
                               input logic [kdv_pkg::NOISE_AMT_W-1:0] amount,
                               input logic [kdv_pkg::LEN_CFG_W-1:0] len);
      csr_write(kdv_pkg::CSR_BODY_PHASE_INC, kdv_pkg::CSR_DATA_W'(body));
      csr_write(kdv_pkg::CSR_PITCH_DEPTH, kdv_pkg::CSR_DATA_W'(depth));
      csr_write(kdv_pkg::CSR_PITCH_DECAY, kdv_pkg::CSR_DATA_W'(pitch_dec));
      csr_write(kdv_pkg::CSR_CLICK_DECAY, kdv_pkg::CSR_DATA_W'(click_dec));
      csr_write(kdv_pkg::CSR_AMP_DECAY, kdv_pkg::CSR_DATA_W'(amp_dec));
      csr_write(kdv_pkg::CSR_NOISE_AMOUNT, kdv_pkg::CSR_DATA_W'(amount));
      csr_write(kdv_pkg::CSR_LENGTH_SAMPLES, kdv_pkg::CSR_DATA_W'(len));
      csr_write(CSR_UNUSED, kdv_pkg::CSR_DATA_W'($urandom));
   endtask

   // One request; bursts of random length separated by random gaps
   task automatic send_tick(input logic retrig, input logic [6:0] vel, input logic [15:0] noise);
      kdv_pkg::req_type item;
      item.retrigger       = retrig;
      item.strike_velocity = vel;
      item.noise_sample    = noise;
      if (burst_left == 0) begin
         if (gap_max > 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, gap_max)) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      burst_left--;
      ticks_sent++;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Hold off the sender until every request has its response
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (samples_owed != 0) @(posedge clock);
   endtask

   function automatic logic [15:0] pick_noise();
      case ($urandom_range(0, 9))
         0: return 16'h8000;
         1: return 16'h7FFF;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [6:0] pick_velocity();
      case ($urandom_range(0, 9))
         0: return 7'd0;
         1: return 7'd127;
         default: return 7'($urandom);
      endcase
   endfunction

   function automatic logic [kdv_pkg::DECAY_W-1:0] pick_decay();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return kdv_pkg::ENV_ONE;
         2: return kdv_pkg::DECAY_W'($urandom);
         default: return kdv_pkg::DECAY_W'($urandom_range(16600000, 16777215));
      endcase
   endfunction

   function automatic logic [kdv_pkg::BODY_INC_W-1:0] pick_body();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         2: return kdv_pkg::BODY_INC_W'($urandom);
         default: return kdv_pkg::BODY_INC_W'($urandom_range(1000, 20000000));
      endcase
   endfunction

   function automatic logic [kdv_pkg::DEPTH_W-1:0] pick_depth();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         default: return kdv_pkg::DEPTH_W'($urandom);
      endcase
   endfunction

   function automatic logic [kdv_pkg::NOISE_AMT_W-1:0] pick_amount();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return kdv_pkg::NOISE_AMT_MAX;
         2: return AMT_TOP;
         default: return kdv_pkg::NOISE_AMT_W'($urandom);
      endcase
   endfunction

   function automatic logic [kdv_pkg::LEN_CFG_W-1:0] pick_length();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return LEN_TOP;
         2: return kdv_pkg::LEN_CFG_W'(1);
         default: return kdv_pkg::LEN_CFG_W'($urandom_range(2, 60));
      endcase
   endfunction

   initial begin
      int                            phase_end;
      int                            tail;
      logic [kdv_pkg::LEN_CFG_W-1:0] voice_len;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Default registers: idle tick before any strike, then a full-scale strike
      send_tick(1'b0, 7'd5, 16'h1234);
      send_tick(1'b1, 7'd127, 16'h7FFF);
      send_tick(1'b0, 7'd0, 16'h8000);
      send_tick(1'b0, 7'd0, 16'h0000);
      wait_for_drain();

      // Top values, noise amount above one; restart mid-voice at zero velocity, run off the end
      apply_config('1, '1, kdv_pkg::ENV_ONE, kdv_pkg::ENV_ONE, kdv_pkg::ENV_ONE, AMT_TOP,
                   kdv_pkg::LEN_CFG_W'(6));
      send_tick(1'b1, 7'd127, 16'h7FFF);
      send_tick(1'b0, 7'd3, 16'h8000);
      send_tick(1'b0, 7'd9, 16'h7FFF);
      send_tick(1'b1, 7'd0, 16'h8000);
      send_tick(1'b0, 7'd0, 16'h3039);
      send_tick(1'b0, 7'd0, 16'hFFFF);
      send_tick(1'b0, 7'd0, 16'h0000);
      send_tick(1'b0, 7'd0, 16'h0001);
      send_tick(1'b0, 7'd0, 16'h7FFF);
      send_tick(1'b0, 7'd0, 16'h8000);
      wait_for_drain();

      // Zero length: strikes give only silent samples
      apply_config('0, '0, '0, '0, '0, '0, '0);
      send_tick(1'b1, 7'd127, 16'h7FFF);
      send_tick(1'b0, 7'd127, 16'h1234);
      send_tick(1'b1, 7'd64, 16'h8000);
      wait_for_drain();

      // Longest length, envelopes collapsing after one tick, noise at unity
      apply_config(pick_body(), kdv_pkg::PITCH_UNITY[kdv_pkg::DEPTH_W-1:0], '0, '0, '0,
                   kdv_pkg::NOISE_AMT_MAX, LEN_TOP);
      send_tick(1'b1, 7'd1, 16'h8000);
      send_tick(1'b0, 7'd1, 16'h8000);
      send_tick(1'b0, 7'd1, 16'h7FFF);
      send_tick(1'b0, 7'd1, 16'h8000);
      wait_for_drain();

      // Random phases: mostly a strike followed by its tail, some stray ticks
      while (ticks_sent < TARGET_TICKS) begin
         wait_for_drain();
         voice_len = pick_length();
         apply_config(pick_body(), pick_depth(), pick_decay(), pick_decay(), pick_decay(),
                      pick_amount(), voice_len);
         gap_max    = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         burst_left = 0;
         phase_end  = ticks_sent + $urandom_range(60, 160);
         while (ticks_sent < phase_end) begin
            if ($urandom_range(0, 4) != 0) begin
               send_tick(1'b1, pick_velocity(), pick_noise());
               tail = (voice_len > 77) ? 80 : int'(voice_len) + 3;
               tail = $urandom_range(0, tail);
               repeat (tail)
                  send_tick($urandom_range(0, 19) == 0, 7'($urandom), pick_noise());
            end else begin
               repeat ($urandom_range(1, 6))
                  send_tick(1'($urandom_range(0, 1)), 7'($urandom), 16'($urandom));
            end
         end
      end

      // Let everything come back, then watch for stray responses
      wait_for_drain();
      repeat (DRAIN_TAIL) @(posedge clock);
      if (mismatches == 0 && samples_owed == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

// File: files.f
hw/rtl/kdv_pkg.sv
hw/rtl/kdv_ctrl.sv
hw/rtl/kick_drum_voice_unit.sv
test/kdv_result_checker.sv
test/kick_drum_voice_unit_tb.sv
